>>> hw/rtl/tam_pkg.sv
// Shared types, constants and the arctangent table for the tilt angle averager.
`timescale 1ns / 1ps
package tam_pkg;

  localparam int STEP_W       = 5;
  localparam int CORDIC_STEPS = 20;
  localparam int SQRT_STEPS   = 32;
  localparam int AXIS_W       = 16;
  localparam int TRIM_W       = 12;
  localparam int OUT_W        = 13;
  localparam int OUT_LIMIT    = 3600;
  localparam int CORDIC_W     = 36;
  localparam int ACC_W        = 27;
  localparam int TABLE_FRAC   = 16;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PITCH_TRIM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_TRIM  = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ0,
    ST_SQ1,
    ST_SQRT,
    ST_ROLL_INIT,
    ST_ROLL,
    ST_RING_RD,
    ST_RING_UPD,
    ST_DIV_INIT,
    ST_DIV,
    ST_FINISH
  } tam_state_e;

  typedef struct packed {
    logic              load_in;
    logic              sq0;
    logic              sq1;
    logic              sqrt_step;
    logic              cordic_step;
    logic              pitch_init;
    logic              roll_init;
    logic              ring_rd;
    logic              ring_upd;
    logic              div_init;
    logic              div_step;
    logic              out_load;
    logic [STEP_W-1:0] step;
  } tam_cmd_t;

  // atan(2^-i) in degrees, scaled by 2^16 and rounded to nearest.
  function automatic logic [23:0] atan_entry(input logic [STEP_W-1:0] idx);
    logic [23:0] v;
    case (idx)
      5'd0:    v = 24'd2949120;
      5'd1:    v = 24'd1740967;
      5'd2:    v = 24'd919879;
      5'd3:    v = 24'd466945;
      5'd4:    v = 24'd234379;
      5'd5:    v = 24'd117304;
      5'd6:    v = 24'd58666;
      5'd7:    v = 24'd29335;
      5'd8:    v = 24'd14668;
      5'd9:    v = 24'd7334;
      5'd10:   v = 24'd3667;
      5'd11:   v = 24'd1833;
      5'd12:   v = 24'd917;
      5'd13:   v = 24'd458;
      5'd14:   v = 24'd229;
      5'd15:   v = 24'd115;
      5'd16:   v = 24'd57;
      5'd17:   v = 24'd29;
      5'd18:   v = 24'd14;
      5'd19:   v = 24'd7;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/tam_ctrl.sv
// Sequencing state machine for the tilt angle averager.
`timescale 1ns / 1ps
module tam_ctrl
  import tam_pkg::*;
#(
  parameter int DIV_STEPS = 17
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tam_cmd_t cmd_o
);

  tam_state_e        state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_SQ0;
      ST_SQ0:       state_d = ST_SQ1;
      ST_SQ1:       state_d = ST_SQRT;
      ST_SQRT:      if (cnt_q == STEP_W'(SQRT_STEPS - 1)) state_d = ST_ROLL_INIT;
      ST_ROLL_INIT: state_d = ST_ROLL;
      ST_ROLL:      if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) state_d = ST_RING_RD;
      ST_RING_RD:   state_d = ST_RING_UPD;
      ST_RING_UPD:  state_d = ST_DIV_INIT;
      ST_DIV_INIT:  state_d = ST_DIV;
      ST_DIV:       if (cnt_q == STEP_W'(DIV_STEPS - 1)) state_d = ST_FINISH;
      ST_FINISH:    if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.step = cnt_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_SQ0: begin
        cmd_o.sq0        = 1'b1;
        cmd_o.pitch_init = 1'b1;
      end
      ST_SQ1:       cmd_o.sq1 = 1'b1;
      ST_SQRT: begin
        cmd_o.sqrt_step   = 1'b1;
        cmd_o.cordic_step = (cnt_q < STEP_W'(CORDIC_STEPS));
      end
      ST_ROLL_INIT: cmd_o.roll_init = 1'b1;
      ST_ROLL:      cmd_o.cordic_step = 1'b1;
      ST_RING_RD:   cmd_o.ring_rd = 1'b1;
      ST_RING_UPD:  cmd_o.ring_upd = 1'b1;
      ST_DIV_INIT:  cmd_o.div_init = 1'b1;
      ST_DIV:       cmd_o.div_step = 1'b1;
      ST_FINISH:    cmd_o.out_load = !out_valid_q || out_ready_i;
      default:      cmd_o = '0;
    endcase
  end

  assign cnt_d       = (state_d != state_q) ? '0 : cnt_q + 1'b1;
  assign out_valid_d = cmd_o.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> hw/rtl/tam_dp.sv
// Datapath: squares, square root, shared CORDIC, angle rings, running sums and divider.
`timescale 1ns / 1ps
module tam_dp
  import tam_pkg::*;
#(
  parameter int WINDOW_DEPTH    = 10,
  parameter int ANGLE_FRAC_BITS = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tam_cmd_t                 cmd_i,
  input  logic signed [AXIS_W-1:0] accel_x_i,
  input  logic signed [AXIS_W-1:0] accel_y_i,
  input  logic signed [AXIS_W-1:0] accel_z_i,
  input  logic signed [TRIM_W-1:0] pitch_trim_i,
  input  logic signed [TRIM_W-1:0] roll_trim_i,
  output logic signed [OUT_W-1:0]  pitch_tenths_o,
  output logic signed [OUT_W-1:0]  roll_tenths_o
);

  localparam int ANG_W  = ANGLE_FRAC_BITS + 9;
  localparam int TOT_W  = ANG_W + $clog2(WINDOW_DEPTH + 1);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int N2_W   = TOT_W + 5;
  localparam int P_W    = TOT_W + 4 - ANGLE_FRAC_BITS;
  localparam int V_W    = P_W + 2;
  localparam int RSH    = TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam logic [ACC_W:0] HALF = (RSH == 0) ? '0 : (ACC_W + 1)'(1 << (RSH - 1));
  localparam logic [ACC_W:0] ANG_LIM = (ACC_W + 1)'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [ACC_W-1:0] ACC_90 = ACC_W'(90 << TABLE_FRAC);

  // Input sample and squares.
  logic signed [AXIS_W-1:0] ax_q, ay_q, az_q;
  logic signed [31:0]       prod_q;
  logic signed [31:0]       az_sq;
  logic [31:0]              sq_sum;

  // Square root.
  logic [63:0] srem_q, sres_q, sbit, strial;

  // CORDIC.
  logic signed [CORDIC_W-1:0] cx_q, cy_q, num, den, ix, iy, dx, dy;
  logic signed [ACC_W-1:0]    cacc_q, iacc, tab;
  logic                       czero_q;
  logic [ACC_W-1:0]           amag;
  logic [ACC_W:0]             arnd, alim;
  logic signed [ANG_W-1:0]    ang, pitch_ang_q, roll_ang_q;

  // Rings and running sums, lane 0 is pitch and lane 1 is roll.
  logic signed [ANG_W-1:0] pring [WINDOW_DEPTH];
  logic signed [ANG_W-1:0] rring [WINDOW_DEPTH];
  logic signed [ANG_W-1:0] old_q [2];
  logic signed [ANG_W-1:0] new_ang [2];
  logic signed [TOT_W-1:0] tot_q [2];
  logic [SLOT_W-1:0]       slot_q;
  logic                    full_q;

  // Divider.
  logic [CNT_W-1:0]        count, dcnt_q;
  logic [TOT_W-1:0]        tmag [2];
  logic [N2_W-1:0]         n2 [2];
  logic [P_W-1:0]          dq_q [2];
  logic [CNT_W-1:0]        rem_q [2];
  logic                    neg_q [2];
  logic [CNT_W:0]          dtry [2];
  logic signed [V_W-1:0]   v [2];
  logic signed [OUT_W-1:0] res [2];
  logic signed [TRIM_W-1:0] trim [2];

  assign az_sq  = az_q * az_q;
  assign sq_sum = $unsigned(prod_q) + $unsigned(az_sq);
  assign sbit   = 64'h4000_0000_0000_0000 >> {cmd_i.step, 1'b0};
  assign strial = sres_q + sbit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
    end
    if (cmd_i.sq0) prod_q <= ay_q * ay_q;
    if (cmd_i.sq1) begin
      srem_q <= {sq_sum, 32'd0};
      sres_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      if (srem_q >= strial) begin
        srem_q <= srem_q - strial;
        sres_q <= (sres_q >> 1) + sbit;
      end else begin
        sres_q <= sres_q >> 1;
      end
    end
  end

  // Operand selection and the quadrant pre-turn.
  always_comb begin
    if (cmd_i.roll_init) begin
      num = -$signed({{(CORDIC_W-32){ax_q[AXIS_W-1]}}, ax_q, 16'd0});
      den = $signed({{(CORDIC_W-32){1'b0}}, sres_q[31:0]});
    end else begin
      num = $signed({{(CORDIC_W-32){ay_q[AXIS_W-1]}}, ay_q, 16'd0});
      den = $signed({{(CORDIC_W-32){az_q[AXIS_W-1]}}, az_q, 16'd0});
    end
    if (den < 0) begin
      if (num >= 0) begin
        ix   = num;
        iy   = -den;
        iacc = ACC_90;
      end else begin
        ix   = -num;
        iy   = den;
        iacc = -ACC_90;
      end
    end else begin
      ix   = den;
      iy   = num;
      iacc = '0;
    end
  end

  assign dx  = cy_q >>> cmd_i.step;
  assign dy  = cx_q >>> cmd_i.step;
  assign tab = $signed({3'b000, atan_entry(cmd_i.step)});

  always_ff @(posedge clk_i) begin
    if (cmd_i.pitch_init || cmd_i.roll_init) begin
      cx_q    <= ix;
      cy_q    <= iy;
      cacc_q  <= iacc;
      czero_q <= (num == 0) && (den == 0);
    end else if (cmd_i.cordic_step) begin
      if (!cy_q[CORDIC_W-1]) begin
        cx_q   <= cx_q + dx;
        cy_q   <= cy_q - dy;
        cacc_q <= cacc_q + tab;
      end else begin
        cx_q   <= cx_q - dx;
        cy_q   <= cy_q + dy;
        cacc_q <= cacc_q - tab;
      end
    end
  end

  // Round the accumulator half away from zero and clamp to +-180 degrees.
  always_comb begin
    amag = cacc_q[ACC_W-1] ? ACC_W'(-cacc_q) : ACC_W'(cacc_q);
    arnd = ({1'b0, amag} + HALF) >> RSH;
    alim = (arnd > ANG_LIM) ? ANG_LIM : arnd;
    if (czero_q) begin
      ang = '0;
    end else if (cacc_q[ACC_W-1]) begin
      ang = ANG_W'(-$signed(alim));
    end else begin
      ang = ANG_W'($signed(alim));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.roll_init) pitch_ang_q <= ang;
    if (cmd_i.ring_rd)   roll_ang_q <= ang;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_rd) begin
      old_q[0] <= pring[slot_q];
      old_q[1] <= rring[slot_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_upd) begin
      pring[slot_q] <= pitch_ang_q;
      rring[slot_q] <= roll_ang_q;
    end
  end

  assign new_ang[0] = pitch_ang_q;
  assign new_ang[1] = roll_ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      full_q   <= 1'b0;
      tot_q[0] <= '0;
      tot_q[1] <= '0;
    end else if (cmd_i.ring_upd) begin
      for (int l = 0; l < 2; l++) begin
        tot_q[l] <= tot_q[l] - (full_q ? TOT_W'(old_q[l]) : '0) + TOT_W'(new_ang[l]);
      end
      if (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) begin
        slot_q <= '0;
        full_q <= 1'b1;
      end else begin
        slot_q <= slot_q + 1'b1;
      end
    end
  end

  // Mean in tenths: floor((20*|total| + count*2^F) / (count*2^(F+1))).
  always_comb begin
    count = full_q ? CNT_W'(WINDOW_DEPTH) : CNT_W'(slot_q);
    for (int l = 0; l < 2; l++) begin
      tmag[l] = tot_q[l][TOT_W-1] ? TOT_W'(-tot_q[l]) : TOT_W'(tot_q[l]);
      n2[l]   = (N2_W'(tmag[l]) << 4) + (N2_W'(tmag[l]) << 2)
              + (N2_W'(count) << ANGLE_FRAC_BITS);
      dtry[l] = {rem_q[l], dq_q[l][P_W-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dcnt_q <= count;
      for (int l = 0; l < 2; l++) begin
        dq_q[l]  <= n2[l][N2_W-1:ANGLE_FRAC_BITS+1];
        rem_q[l] <= '0;
        neg_q[l] <= tot_q[l][TOT_W-1];
      end
    end else if (cmd_i.div_step) begin
      for (int l = 0; l < 2; l++) begin
        if (dtry[l] >= {1'b0, dcnt_q}) begin
          rem_q[l] <= CNT_W'(dtry[l] - {1'b0, dcnt_q});
          dq_q[l]  <= {dq_q[l][P_W-2:0], 1'b1};
        end else begin
          rem_q[l] <= dtry[l][CNT_W-1:0];
          dq_q[l]  <= {dq_q[l][P_W-2:0], 1'b0};
        end
      end
    end
  end

  assign trim[0] = pitch_trim_i;
  assign trim[1] = roll_trim_i;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      v[l] = neg_q[l] ? -$signed({2'b00, dq_q[l]}) : $signed({2'b00, dq_q[l]});
      v[l] = v[l] + V_W'(trim[l]);
      if (v[l] > V_W'(OUT_LIMIT)) begin
        res[l] = OUT_W'(OUT_LIMIT);
      end else if (v[l] < -V_W'(OUT_LIMIT)) begin
        res[l] = -OUT_W'(OUT_LIMIT);
      end else begin
        res[l] = OUT_W'(v[l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pitch_tenths_o <= res[0];
      roll_tenths_o  <= res[1];
    end
  end

endmodule

>>> hw/rtl/tilt_angle_moving_average.sv
// Top level of the accelerometer tilt angle moving average block.
//
// Usage: one three-axis accelerometer word enters on the s_axis channel and
// one word with averaged pitch and roll, in tenths of a degree, leaves on the
// m_axis channel. Pitch is atan2(y, z), roll is atan2(-x, sqrt(y*y + z*z)).
// Both angles are averaged over the last WINDOW_DEPTH samples, or over the
// samples seen so far before the window has filled, then the trims are added.
// The user must write the trims through the cfg port only while the block is
// idle; the block itself does not enforce this.
//
// One word is in flight at a time; the next input word can be taken in the
// cycle after the result is loaded. The mean divider has a quotient width of
// 17 bits at the default parameters. Most of the work for a word lies in the
// 32-step bit-serial square root (the pitch CORDIC runs beside it), the
// 20-step roll CORDIC on the same unit, and the bit-serial divider that
// serves both lanes in parallel.
//
// Reset clears the window, the running sums and the trims. A finished result
// sits in the output register; a stalled receiver does not block the next
// input word, but the word after that waits until the result is taken.
`timescale 1ns / 1ps
module tilt_angle_moving_average
  import tam_pkg::*;
#(
  parameter int WINDOW_DEPTH    = 10,
  parameter int ANGLE_FRAC_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tdata: accel_x [15:0], accel_y [31:16], accel_z [47:32]
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,
  // tdata: pitch_tenths [12:0], roll_tenths [25:13], zero [31:26]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TRIM_W-1:0]    cfg_data_i
);

  localparam int ANG_W     = ANGLE_FRAC_BITS + 9;
  localparam int TOT_W     = ANG_W + $clog2(WINDOW_DEPTH + 1);
  localparam int DIV_STEPS = TOT_W + 4 - ANGLE_FRAC_BITS;

  tam_cmd_t                cmd;
  logic signed [TRIM_W-1:0] pitch_trim_q, roll_trim_q;
  logic signed [OUT_W-1:0]  pitch_tenths, roll_tenths;

  // Trim registers; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_trim_q <= '0;
      roll_trim_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PITCH_TRIM: pitch_trim_q <= $signed(cfg_data_i);
        REG_ROLL_TRIM:  roll_trim_q  <= $signed(cfg_data_i);
        default:        ;
      endcase
    end
  end

  tam_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  tam_dp #(
    .WINDOW_DEPTH    (WINDOW_DEPTH),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .accel_x_i      ($signed(s_axis_tdata[15:0])),
    .accel_y_i      ($signed(s_axis_tdata[31:16])),
    .accel_z_i      ($signed(s_axis_tdata[47:32])),
    .pitch_trim_i   (pitch_trim_q),
    .roll_trim_i    (roll_trim_q),
    .pitch_tenths_o (pitch_tenths),
    .roll_tenths_o  (roll_tenths)
  );

  assign m_axis_tdata = {6'd0, roll_tenths, pitch_tenths};

  // Only one word is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a word is in flight");

  // A new result never overwrites one the receiver has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

  // Results stay inside the saturation range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[12:0]) <= 13'sd3600) &&
                      ($signed(m_axis_tdata[12:0]) >= -13'sd3600) &&
                      ($signed(m_axis_tdata[25:13]) <= 13'sd3600) &&
                      ($signed(m_axis_tdata[25:13]) >= -13'sd3600))
    else $error("result out of range");

endmodule
